@@ rtl/bolla_pkg.sv @@
`default_nettype none

package bolla_pkg;

  // default sizing of the user table and feedback counters, and the default hold-off length in TTIs
  localparam int USERS_DEF      = 64;
  localparam int COUNT_BITS_DEF = 24;
  localparam int HOLD_TTIS_DEF  = 4;

  // fixed field widths
  localparam int USER_W      = 6;
  localparam int TTI_W       = 24;
  localparam int CNT_IN_W    = 24;
  localparam int TH_W        = 24;
  localparam int IV_W        = 14;
  localparam int ACK_STEP_W  = 21;
  localparam int NACK_STEP_W = 21;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;

  // second operand of the shared multiplier: a sign-extended ACK step, a zero-extended NACK step or a zero-extended tti
  localparam int MUL_BW = TTI_W + 1;

  // scaled step magnitude: quotient bits kept and the clip value (512 dB in Q16)
  localparam int                  QUOT_W  = 26;
  localparam logic [QUOT_W-1:0]   MAG_CAP = 26'h2000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPDATE_INTERVAL   = 2'd0,
    CFG_ACK_STEP          = 2'd1,
    CFG_NACK_STEP         = 2'd2,
    CFG_INITIAL_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [USER_W-1:0]     user;
    logic [TTI_W-1:0]      tti;
    logic                  user_known;
    logic [CNT_IN_W-1:0]   ack_total;
    logic [CNT_IN_W-1:0]   nack_total;
  } in_word_t;

  typedef struct packed {
    logic [USER_W-1:0]      user_out;
    logic signed [TH_W-1:0] threshold;
    logic                   adjusted;
    logic                   held_off;
    logic                   saturated;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/bler_outer_loop_link_adaptation_core.sv @@
`default_nettype none

// Outer-loop link adaptation driven by HARQ ACK/NACK counts, one table entry per user
// holding the last counts, a hold-off end TTI and a Q16 dB threshold offset. Each input
// word gives exactly one output word. After reset the block zeroes every table entry
// and keeps in_ready low meanwhile; configuration writes are taken at any time.
// in_ready is high only while the sequencer is idle. An accepted word goes to the output
// for a clear, an unknown user or a user beyond the table, after the interval check for
// an update whose TTI is not a multiple of the interval, after the evaluation when new
// feedback is only recorded during the hold-off, and otherwise once the threshold is
// recomputed, with no divide if the ACK plus NACK sum is zero or if the scaled step is
// clipped before it. The shared arithmetic unit does one restoring divide step per cycle:
// 24 steps for the TTI interval check and 26 for the scaled step. A finished word sits
// in the output register while the next input word is taken; a word whose predecessor
// is still waiting there stays in its last cycle until the output register is free.
module bler_outer_loop_link_adaptation_core
  import bolla_pkg::*;
#(
  parameter int USERS      = USERS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int HOLD_TTIS  = HOLD_TTIS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word
);

  localparam int CW      = COUNT_BITS;
  localparam int SUM_W   = CW + 1;
  localparam int OFF_W   = CW + 23;
  localparam int MAG_W   = CW + 22;
  localparam int HW      = (MAG_W + 1) / 2;
  localparam int MUL_AW  = ((CW > HW) ? CW : HW) + 1;
  localparam int MUL_PW  = MUL_AW + MUL_BW;
  localparam int PROD_W  = MAG_W + TTI_W;
  localparam int HI_W    = PROD_W - QUOT_W;
  localparam int DIV_W   = (SUM_W > IV_W) ? SUM_W : IV_W;
  localparam int UA      = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int ENT_W   = 2 * CW + TTI_W + TH_W;
  localparam int CNT_W   = $clog2(QUOT_W);
  localparam int TH_X_W  = TH_W + 3;

  localparam logic [UA-1:0]          CLR_LAST = UA'(USERS - 1);
  localparam int                     TH_MAX   = 8388607;
  localparam int                     TH_MIN   = -8388608;
  localparam logic [IV_W-1:0]        IV_RESET        = 14'd10;
  localparam logic [ACK_STEP_W-1:0]  ACK_STEP_RESET  = 21'h1FF1C7;
  localparam logic [NACK_STEP_W-1:0] NACK_STEP_RESET = 21'd32768;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FETCH, S_MOD, S_EVAL, S_MUL_A, S_MUL_N, S_MAG,
    S_MUL_L, S_MUL_H, S_DCHK, S_DIV, S_APPLY, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [IV_W-1:0]               update_interval;
  logic signed [ACK_STEP_W-1:0]  ack_step;
  logic [NACK_STEP_W-1:0]        nack_step;
  logic signed [TH_W-1:0]        initial_threshold;

  // working registers
  in_word_t               item;
  logic [UA-1:0]          clr_idx;
  logic [CW-1:0]          e_ack;
  logic [CW-1:0]          e_nack;
  logic [TTI_W-1:0]       e_hold;
  logic signed [TH_W-1:0] e_th;
  logic [CNT_W-1:0]       cnt;
  logic [DIV_W-1:0]       rem;
  logic [SUM_W-1:0]       sum_q;
  logic [CW-1:0]          da;
  logic [CW-1:0]          dn;
  logic signed [OFF_W-1:0] acc;
  logic                   neg;
  logic [MAG_W-1:0]       mag;
  logic [PROD_W-1:0]      acc2;
  logic [QUOT_W-1:0]      res_mag;
  logic [TTI_W-1:0]       hold_new;
  logic signed [TH_W-1:0] res_th;
  logic                   res_adj;
  logic                   res_held;
  logic                   res_sat;

  // table port
  logic             ram_wr_en;
  logic [UA-1:0]    ram_wr_addr;
  logic [ENT_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [ENT_W-1:0] ram_rd_data;

  // shared unit port
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic [MUL_PW-1:0]        mul_pu;
  logic                     div_bit;
  logic [DIV_W-1:0]         div_den;
  logic [DIV_W-1:0]         div_rem_next;
  logic                     div_q;

  // decode of the current entry and item
  logic [CW-1:0]           rd_ack;
  logic [CW-1:0]           rd_nack;
  logic [TTI_W-1:0]        rd_hold;
  logic signed [TH_W-1:0]  rd_th;
  logic [CW-1:0]           ca;
  logic [CW-1:0]           cn;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]        last_sum;
  logic                    new_fb;
  logic                    user_ok;
  logic [IV_W-1:0]         iv_eff;
  logic [OFF_W-1:0]        acc_abs;
  logic [QUOT_W-1:0]       acc2_lo;
  logic [HI_W-1:0]         acc2_hi;
  logic [QUOT_W-1:0]       mag_c;
  logic signed [TH_X_W-1:0] th_sum;
  logic signed [TH_W-1:0]  th_new;
  logic                    sat_new;

  assign in_ready = (state == S_IDLE);

  assign rd_ack  = ram_rd_data[ENT_W-1 -: CW];
  assign rd_nack = ram_rd_data[ENT_W-CW-1 -: CW];
  assign rd_hold = ram_rd_data[TH_W+TTI_W-1 -: TTI_W];
  assign rd_th   = ram_rd_data[TH_W-1:0];

  assign ca       = CW'(item.ack_total);
  assign cn       = CW'(item.nack_total);
  assign sum      = {1'b0, ca} + {1'b0, cn};
  assign last_sum = {1'b0, e_ack} + {1'b0, e_nack};
  assign new_fb   = (sum > last_sum);
  assign user_ok  = (int'(item.user) < USERS);
  assign iv_eff   = (update_interval == '0) ? IV_W'(1) : update_interval;
  assign acc_abs  = acc[OFF_W-1] ? OFF_W'(-acc) : OFF_W'(acc);
  assign acc2_lo  = acc2[QUOT_W-1:0];
  assign acc2_hi  = acc2[PROD_W-1:QUOT_W];
  assign mul_pu   = mul_p;

  // clip the step magnitude, apply it and saturate to the threshold range
  always_comb begin
    if (sum_q == '0) begin
      mag_c = (mag > MAG_W'(MAG_CAP)) ? MAG_CAP : mag[QUOT_W-1:0];
    end else begin
      mag_c = (res_mag > MAG_CAP) ? MAG_CAP : res_mag;
    end
    if (neg) begin
      th_sum = {{3{e_th[TH_W-1]}}, e_th} - {1'b0, mag_c};
    end else begin
      th_sum = {{3{e_th[TH_W-1]}}, e_th} + {1'b0, mag_c};
    end
    sat_new = 1'b0;
    th_new  = th_sum[TH_W-1:0];
    if (th_sum > TH_MAX) begin
      th_new  = TH_W'(TH_MAX);
      sat_new = 1'b1;
    end else if (th_sum < TH_MIN) begin
      th_new  = TH_W'(TH_MIN);
      sat_new = 1'b1;
    end
  end

  // operand select for the shared unit
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_A: begin
        mul_a = MUL_AW'(da);
        mul_b = {{(MUL_BW - ACK_STEP_W){ack_step[ACK_STEP_W-1]}}, ack_step};
      end
      S_MUL_N: begin
        mul_a = MUL_AW'(dn);
        mul_b = MUL_BW'(nack_step);
      end
      S_MUL_L: begin
        mul_a = MUL_AW'(mag[HW-1:0]);
        mul_b = MUL_BW'(item.tti);
      end
      S_MUL_H: begin
        mul_a = MUL_AW'(mag[MAG_W-1:HW]);
        mul_b = MUL_BW'(item.tti);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    if (state == S_MOD) begin
      div_den = DIV_W'(iv_eff);
      div_bit = item.tti[cnt];
    end else begin
      div_den = DIV_W'(sum_q);
      div_bit = acc2_lo[cnt];
    end
  end

  // table read at accept, writes from the clearing pass and the write-back states
  always_comb begin
    ram_rd_en   = in_valid && in_ready;
    ram_wr_en   = 1'b0;
    ram_wr_addr = UA'(item.user);
    ram_wr_data = {ca, cn, e_hold, e_th};
    case (state)
      S_CLR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx;
        ram_wr_data = '0;
      end
      S_FETCH: begin
        ram_wr_en   = user_ok && (item.opcode == OP_CLEAR);
        ram_wr_data = {{(2 * CW + TTI_W){1'b0}}, initial_threshold};
      end
      S_EVAL: begin
        ram_wr_en = new_fb && (e_hold > item.tti);
      end
      S_APPLY: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = {ca, cn, hold_new, th_new};
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  bolla_ram #(
    .WIDTH (ENT_W),
    .DEPTH (USERS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (UA'(in_word.user)),
    .rd_data (ram_rd_data)
  );

  bolla_unit #(
    .MUL_AW (MUL_AW),
    .DIV_W  (DIV_W)
  ) u_unit (
    .mul_a        (mul_a),
    .mul_b        (mul_b),
    .mul_p        (mul_p),
    .div_rem      (rem),
    .div_bit      (div_bit),
    .div_den      (div_den),
    .div_rem_next (div_rem_next),
    .div_q        (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval   <= IV_RESET;
      ack_step          <= ACK_STEP_RESET;
      nack_step         <= NACK_STEP_RESET;
      initial_threshold <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_UPDATE_INTERVAL:   update_interval   <= cfg_wdata[IV_W-1:0];
        CFG_ACK_STEP:          ack_step          <= cfg_wdata[ACK_STEP_W-1:0];
        CFG_NACK_STEP:         nack_step         <= cfg_wdata[NACK_STEP_W-1:0];
        CFG_INITIAL_THRESHOLD: initial_threshold <= cfg_wdata[TH_W-1:0];
        default:               update_interval   <= update_interval;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // drained output register, unless a new word is loaded this cycle
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_word;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          e_ack    <= rd_ack;
          e_nack   <= rd_nack;
          e_hold   <= rd_hold;
          e_th     <= rd_th;
          rem      <= '0;
          cnt      <= CNT_W'(TTI_W - 1);
          res_adj  <= 1'b0;
          res_held <= 1'b0;
          res_sat  <= 1'b0;
          if (!user_ok) begin
            res_th <= '0;
            state  <= S_OUT;
          end else if (item.opcode == OP_CLEAR) begin
            res_th  <= initial_threshold;
            res_adj <= (initial_threshold != rd_th);
            state   <= S_OUT;
          end else if (!item.user_known) begin
            res_th <= rd_th;
            state  <= S_OUT;
          end else begin
            state <= S_MOD;
          end
        end
        // tti modulo the update interval, one bit per cycle
        S_MOD: begin
          rem <= div_rem_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (div_rem_next != '0) begin
              res_th <= e_th;
              state  <= S_OUT;
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          sum_q <= sum;
          da    <= ca - e_ack;
          dn    <= cn - e_nack;
          if (new_fb && (e_hold > item.tti)) begin
            res_th   <= e_th;
            res_held <= 1'b1;
            state    <= S_OUT;
          end else begin
            hold_new <= new_fb ? (item.tti + TTI_W'(HOLD_TTIS)) : e_hold;
            state    <= S_MUL_A;
          end
        end
        // raw offset: dack * ack_step + dnack * nack_step
        S_MUL_A: begin
          acc   <= $signed(mul_pu[OFF_W-1:0]);
          state <= S_MUL_N;
        end
        S_MUL_N: begin
          acc   <= acc + $signed(mul_pu[OFF_W-1:0]);
          state <= S_MAG;
        end
        S_MAG: begin
          neg <= acc[OFF_W-1];
          mag <= acc_abs[MAG_W-1:0];
          if (sum_q == '0) begin
            state <= S_APPLY;
          end else begin
            state <= S_MUL_L;
          end
        end
        // magnitude times tti in two partial products
        S_MUL_L: begin
          acc2  <= PROD_W'(mul_pu);
          state <= S_MUL_H;
        end
        S_MUL_H: begin
          acc2  <= acc2 + (PROD_W'(mul_pu) << HW);
          state <= S_DCHK;
        end
        // quotient too large for the kept bits means the clip applies
        S_DCHK: begin
          if (acc2_hi >= HI_W'(sum_q)) begin
            res_mag <= MAG_CAP;
            state   <= S_APPLY;
          end else begin
            rem   <= DIV_W'(acc2_hi);
            cnt   <= CNT_W'(QUOT_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= div_rem_next;
          res_mag <= {res_mag[QUOT_W-2:0], div_q};
          cnt     <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          res_th  <= th_new;
          res_adj <= (th_new != e_th);
          res_sat <= sat_new;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_word.user_out  <= item.user;
            out_word.threshold <= res_th;
            out_word.adjusted  <= res_adj;
            out_word.held_off  <= res_held;
            out_word.saturated <= res_sat;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/bolla_ram.sv @@
`default_nettype none

module bolla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bolla_unit.sv @@
`default_nettype none

module bolla_unit
  import bolla_pkg::*;
#(
  parameter int MUL_AW = 25,
  parameter int DIV_W  = 25
) (
  input  logic signed [MUL_AW-1:0]        mul_a,
  input  logic signed [MUL_BW-1:0]        mul_b,
  output logic signed [MUL_AW+MUL_BW-1:0] mul_p,
  input  logic [DIV_W-1:0]                div_rem,
  input  logic                            div_bit,
  input  logic [DIV_W-1:0]                div_den,
  output logic [DIV_W-1:0]                div_rem_next,
  output logic                            div_q
);

  logic [DIV_W:0] trial;
  logic [DIV_W:0] den_x;
  logic [DIV_W:0] diff;

  // shared signed multiplier
  assign mul_p = mul_a * mul_b;

  // one restoring divide step: shift in a dividend bit, subtract if it fits
  assign trial        = {div_rem, div_bit};
  assign den_x        = {1'b0, div_den};
  assign diff         = trial - den_x;
  assign div_q        = (trial >= den_x);
  assign div_rem_next = div_q ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

endmodule

`default_nettype wire
